// ===== src/hlcp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlcp_pkg
// Shared types and constants for the hop-limited cheapest path block.
// ----------------------------------------------------------------------------
package hlcp_pkg;

  localparam int CITY_PORT_W  = 6;
  localparam int LIMIT_W      = 6;
  localparam int PRICE_PORT_W = 16;
  localparam int ACTION_W     = 2;
  localparam int CFG_W        = 7;
  localparam int COST_W       = 22;
  localparam int OUT_W        = 23;

  localparam int DEF_MAX_CITIES = 64;
  localparam int DEF_MAX_EDGES  = 1024;
  localparam int DEF_PRICE_BITS = 16;

  localparam logic [CFG_W-1:0]  CITIES_RESET = CFG_W'(64);
  localparam logic [COST_W-1:0] COST_CAP     = {COST_W{1'b1}};

  localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

  typedef struct packed {
    logic [CITY_PORT_W-1:0] src;
    logic [CITY_PORT_W-1:0] dst;
    logic [LIMIT_W-1:0]     limit;
  } hlcp_query_t;

  typedef struct packed {
    logic              reached;
    logic [COST_W-1:0] cost;
  } hlcp_cost_t;

endpackage

// ===== src/hlcp_cost_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlcp_cost_ram
// Per-city cost memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hlcp_cost_ram #(
  parameter int DEPTH = hlcp_pkg::DEF_MAX_CITIES,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  hlcp_pkg::hlcp_cost_t wdata,
  input  logic [AW-1:0]        raddr,
  output hlcp_pkg::hlcp_cost_t rdata
);
  import hlcp_pkg::*;

  hlcp_cost_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/hlcp_edge_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlcp_edge_store
// Edge list memory with fill count and a sticky overflow flag.
// ----------------------------------------------------------------------------
module hlcp_edge_store #(
  parameter int MAX_EDGES  = hlcp_pkg::DEF_MAX_EDGES,
  parameter int PRICE_BITS = hlcp_pkg::DEF_PRICE_BITS,
  parameter int EIDX_W     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  parameter int ECNT_W     = $clog2(MAX_EDGES + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             add_en,
  input  logic                             clr_en,
  input  logic [hlcp_pkg::CITY_PORT_W-1:0] add_origin,
  input  logic [hlcp_pkg::CITY_PORT_W-1:0] add_target,
  input  logic [PRICE_BITS-1:0]            add_price,
  input  logic [EIDX_W-1:0]                rd_addr,
  output logic [hlcp_pkg::CITY_PORT_W-1:0] rd_origin,
  output logic [hlcp_pkg::CITY_PORT_W-1:0] rd_target,
  output logic [PRICE_BITS-1:0]            rd_price,
  output logic [ECNT_W-1:0]                edge_count,
  output logic                             overflow
);
  import hlcp_pkg::*;

  localparam int ENTRY_W = 2 * CITY_PORT_W + PRICE_BITS;

  logic [ENTRY_W-1:0] mem [MAX_EDGES];
  logic [ENTRY_W-1:0] rd_entry;
  logic               has_room;

  assign has_room = 32'(edge_count) < MAX_EDGES;

  always_ff @(posedge clk) begin
    if (add_en && has_room) begin
      mem[edge_count[EIDX_W-1:0]] <= {add_origin, add_target, add_price};
    end
    rd_entry <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
      overflow   <= 1'b0;
    end else if (clr_en) begin
      edge_count <= '0;
    end else if (add_en) begin
      if (has_room) begin
        edge_count <= edge_count + 1'b1;
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  assign rd_origin = rd_entry[ENTRY_W-1 -: CITY_PORT_W];
  assign rd_target = rd_entry[PRICE_BITS +: CITY_PORT_W];
  assign rd_price  = rd_entry[PRICE_BITS-1:0];

endmodule

// ===== src/hlcp_query_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlcp_query_seq
// Query sequencer: cost init, per-round snapshot copy and pipelined relaxation.
// ----------------------------------------------------------------------------
module hlcp_query_seq #(
  parameter int MAX_CITIES = hlcp_pkg::DEF_MAX_CITIES,
  parameter int MAX_EDGES  = hlcp_pkg::DEF_MAX_EDGES,
  parameter int PRICE_BITS = hlcp_pkg::DEF_PRICE_BITS,
  parameter int NCW        = $clog2(MAX_CITIES + 1),
  parameter int EIDX_W     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  parameter int ECNT_W     = $clog2(MAX_EDGES + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                go,
  input  hlcp_pkg::hlcp_query_t               query,
  input  logic [NCW-1:0]                      city_count,
  input  logic [ECNT_W-1:0]                   edge_count,
  output logic [EIDX_W-1:0]                   edge_addr,
  input  logic [hlcp_pkg::CITY_PORT_W-1:0]    edge_origin,
  input  logic [hlcp_pkg::CITY_PORT_W-1:0]    edge_target,
  input  logic [PRICE_BITS-1:0]               edge_price,
  output logic                                busy,
  output logic                                done,
  output logic signed [hlcp_pkg::OUT_W-1:0]   cost
);
  import hlcp_pkg::*;

  localparam int CW = $clog2(MAX_CITIES);
  localparam int SUM_W = 33;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_COPY = 3'd2;
  localparam logic [2:0] ST_EDGE = 3'd3;
  localparam logic [2:0] ST_FRD  = 3'd4;
  localparam logic [2:0] ST_FOUT = 3'd5;

  logic [2:0]            state;
  hlcp_query_t           q;
  logic [NCW-1:0]        n;
  logic [LIMIT_W-1:0]    round;
  logic [NCW-1:0]        ctr;
  logic                  cp_valid;
  logic [CW-1:0]         cp_addr;
  logic [ECNT_W-1:0]     ea;
  logic                  s1_valid;
  logic                  s2_valid;
  logic [CW-1:0]         s2_v;
  logic [PRICE_BITS-1:0] s2_price;
  logic                  fw_valid;
  logic [CW-1:0]         fw_addr;
  hlcp_cost_t            fw_data;

  logic                  best_we;
  logic [CW-1:0]         best_waddr;
  hlcp_cost_t            best_wdata;
  logic [CW-1:0]         best_raddr;
  hlcp_cost_t            best_rdata;
  logic                  prev_we;
  logic [CW-1:0]         prev_waddr;
  logic [CW-1:0]         prev_raddr;
  hlcp_cost_t            prev_rdata;

  logic                  edges_left;
  logic                  s1_in_range;
  hlcp_cost_t            best_cur;
  logic [SUM_W-1:0]      sum;
  logic [COST_W-1:0]     cand;
  logic                  relax_we;
  logic                  query_ok;

  hlcp_cost_ram #(.DEPTH(MAX_CITIES), .AW(CW)) u_best (
    .clk   (clk),
    .we    (best_we),
    .waddr (best_waddr),
    .wdata (best_wdata),
    .raddr (best_raddr),
    .rdata (best_rdata)
  );

  hlcp_cost_ram #(.DEPTH(MAX_CITIES), .AW(CW)) u_prev (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (best_rdata),
    .raddr (prev_raddr),
    .rdata (prev_rdata)
  );

  assign edge_addr   = ea[EIDX_W-1:0];
  assign edges_left  = ea < edge_count;
  assign s1_in_range = (32'(edge_origin) < 32'(n)) && (32'(edge_target) < 32'(n));
  assign query_ok    = (32'(query.src) < 32'(city_count)) &&
                       (32'(query.dst) < 32'(city_count));

  // The write from the previous cycle has not reached the read data yet.
  assign best_cur = (fw_valid && (fw_addr == s2_v)) ? fw_data : best_rdata;
  assign sum      = SUM_W'(prev_rdata.cost) + SUM_W'(s2_price);
  assign cand     = (sum > SUM_W'(COST_CAP)) ? COST_CAP : sum[COST_W-1:0];
  assign relax_we = s2_valid && prev_rdata.reached &&
                    (!best_cur.reached || (cand < best_cur.cost));

  assign prev_we    = cp_valid;
  assign prev_waddr = cp_addr;
  assign prev_raddr = CW'(edge_origin);

  always_comb begin
    best_we    = 1'b0;
    best_waddr = s2_v;
    best_wdata = '{reached: 1'b1, cost: cand};
    best_raddr = CW'(q.dst);
    unique case (state)
      ST_INIT: begin
        best_we    = 1'b1;
        best_waddr = ctr[CW-1:0];
        best_wdata = '{reached: (32'(ctr) == 32'(q.src)), cost: '0};
      end
      ST_COPY: begin
        best_raddr = ctr[CW-1:0];
      end
      ST_EDGE: begin
        best_we    = relax_we;
        best_raddr = CW'(edge_target);
      end
      default: begin
        best_raddr = CW'(q.dst);
      end
    endcase
  end

  assign busy = state != ST_IDLE;

  always_ff @(posedge clk) begin
    s2_v     <= CW'(edge_target);
    s2_price <= edge_price;
    fw_addr  <= s2_v;
    fw_data  <= '{reached: 1'b1, cost: cand};
    if (rst) begin
      state    <= ST_IDLE;
      done     <= 1'b0;
      cp_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      fw_valid <= 1'b0;
    end else begin
      done     <= 1'b0;
      cp_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      fw_valid <= relax_we;
      unique case (state)
        ST_IDLE: begin
          if (go) begin
            q <= query;
            n <= city_count;
            if (query_ok) begin
              state <= ST_INIT;
              ctr   <= '0;
            end else begin
              done <= 1'b1;
              cost <= '1;
            end
          end
        end
        ST_INIT: begin
          ctr <= ctr + 1'b1;
          if (32'(ctr) == 32'(n) - 1) begin
            state <= ST_COPY;
            ctr   <= '0;
            round <= '0;
          end
        end
        ST_COPY: begin
          if (ctr != n) begin
            cp_valid <= 1'b1;
            cp_addr  <= ctr[CW-1:0];
            ctr      <= ctr + 1'b1;
          end else begin
            state <= ST_EDGE;
            ea    <= '0;
          end
        end
        ST_EDGE: begin
          if (edges_left) begin
            s1_valid <= 1'b1;
            ea       <= ea + 1'b1;
          end
          s2_valid <= s1_valid && s1_in_range;
          if (!edges_left && !s1_valid && !s2_valid) begin
            if (round == q.limit) begin
              state <= ST_FRD;
            end else begin
              round <= round + 1'b1;
              state <= ST_COPY;
              ctr   <= '0;
            end
          end
        end
        ST_FRD: begin
          state <= ST_FOUT;
        end
        ST_FOUT: begin
          done  <= 1'b1;
          cost  <= best_rdata.reached ? OUT_W'({1'b0, best_rdata.cost}) : '1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/hop_limited_cheapest_path_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hop_limited_cheapest_path_top
// Cheapest route over a stored edge list with a bound on the number of stops.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Action add appends the
// edge (from_city, to_city, price) to the edge memory and action clear empties
// it; both finish in the accepting cycle and produce no result. An add that
// finds the memory full is dropped and the sticky edges_dropped flag is set
// until reset. Action query runs stop_limit+1 relaxation rounds from
// source_city and returns one result, marked by done for exactly one cycle:
// cheapest_cost holds the least price to dest_city, or -1 when unreachable.
// The receiver cannot hold results off, so done is never delayed.
// A query first writes the start costs of the n cities in use; each round
// then copies the cost snapshot and streams the E stored edges through a
// three-stage read, add, compare and write-back pipeline at one edge a
// cycle, bounded by the single read port of each cost memory. A query
// with an endpoint outside the cities in use answers -1 in the next cycle.
// The cities_in_use register is written through the cfg channel while the
// block is idle. Reset empties the edge list, clears the overflow flag and
// sets cities_in_use to 64; the memories themselves are not cleared.
// ----------------------------------------------------------------------------
module hop_limited_cheapest_path_top #(
  parameter int MAX_CITIES = hlcp_pkg::DEF_MAX_CITIES,
  parameter int MAX_EDGES  = hlcp_pkg::DEF_MAX_EDGES,
  parameter int PRICE_BITS = hlcp_pkg::DEF_PRICE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [hlcp_pkg::ACTION_W-1:0]      action,
  input  logic [hlcp_pkg::CITY_PORT_W-1:0]   from_city,
  input  logic [hlcp_pkg::CITY_PORT_W-1:0]   to_city,
  input  logic [hlcp_pkg::PRICE_PORT_W-1:0]  price,
  input  logic [hlcp_pkg::CITY_PORT_W-1:0]   source_city,
  input  logic [hlcp_pkg::CITY_PORT_W-1:0]   dest_city,
  input  logic [hlcp_pkg::LIMIT_W-1:0]       stop_limit,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hlcp_pkg::CFG_W-1:0]         cfg_data,
  output logic                               done,
  output logic signed [hlcp_pkg::OUT_W-1:0]  cheapest_cost,
  output logic                               edges_dropped
);
  import hlcp_pkg::*;

  localparam int NCW    = $clog2(MAX_CITIES + 1);
  localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECNT_W = $clog2(MAX_EDGES + 1);

  logic [CFG_W-1:0]       cities_in_use;
  logic [NCW-1:0]         city_count;
  logic                   accept;
  logic                   add_en;
  logic                   clr_en;
  logic                   query_go;
  logic [31:0]            price_wide;
  hlcp_query_t            query;
  logic [EIDX_W-1:0]      edge_addr;
  logic [CITY_PORT_W-1:0] edge_origin;
  logic [CITY_PORT_W-1:0] edge_target;
  logic [PRICE_BITS-1:0]  edge_price;
  logic [ECNT_W-1:0]      edge_count;

  // Configuration is only expected while idle; hold it off during a query.
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cities_in_use <= CITIES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cities_in_use <= cfg_data;
    end
  end

  // Counts above the city memory depth behave as the full depth.
  assign city_count = (32'(cities_in_use) > MAX_CITIES) ? NCW'(MAX_CITIES)
                                                        : NCW'(cities_in_use);

  assign accept   = start && !busy;
  assign add_en   = accept && (action == ACT_ADD);
  assign clr_en   = accept && (action == ACT_CLEAR);
  assign query_go = accept && (action == ACT_QUERY);

  assign price_wide = 32'(price);
  assign query      = '{src: source_city, dst: dest_city, limit: stop_limit};

  hlcp_edge_store #(
    .MAX_EDGES  (MAX_EDGES),
    .PRICE_BITS (PRICE_BITS),
    .EIDX_W     (EIDX_W),
    .ECNT_W     (ECNT_W)
  ) u_edges (
    .clk        (clk),
    .rst        (rst),
    .add_en     (add_en),
    .clr_en     (clr_en),
    .add_origin (from_city),
    .add_target (to_city),
    .add_price  (price_wide[PRICE_BITS-1:0]),
    .rd_addr    (edge_addr),
    .rd_origin  (edge_origin),
    .rd_target  (edge_target),
    .rd_price   (edge_price),
    .edge_count (edge_count),
    .overflow   (edges_dropped)
  );

  hlcp_query_seq #(
    .MAX_CITIES (MAX_CITIES),
    .MAX_EDGES  (MAX_EDGES),
    .PRICE_BITS (PRICE_BITS),
    .NCW        (NCW),
    .EIDX_W     (EIDX_W),
    .ECNT_W     (ECNT_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .go          (query_go),
    .query       (query),
    .city_count  (city_count),
    .edge_count  (edge_count),
    .edge_addr   (edge_addr),
    .edge_origin (edge_origin),
    .edge_target (edge_target),
    .edge_price  (edge_price),
    .busy        (busy),
    .done        (done),
    .cost        (cheapest_cost)
  );

endmodule

// ===== tb/sv/route_check_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_check_pkg
// Expected-answer tracking for the hop-limited cheapest path testbench.
// ----------------------------------------------------------------------------
// Mirrors the edge store, the overflow flag and the city count of the block
// and works out each query's answer with stop-limited relaxation rounds.
// ----------------------------------------------------------------------------
package route_check_pkg;

  import hlcp_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic signed [OUT_W-1:0] NO_ROUTE = '1;

  typedef struct packed {
    logic signed [OUT_W-1:0] cost;
    logic                    dropped;
  } route_answer_t;

  class cheapest_route_tracker;
    logic [CITY_PORT_W-1:0]    edge_from  [DEF_MAX_EDGES];
    logic [CITY_PORT_W-1:0]    edge_to    [DEF_MAX_EDGES];
    logic [DEF_PRICE_BITS-1:0] edge_price [DEF_MAX_EDGES];
    int unsigned               stored;
    bit                        store_overflowed;
    logic [CFG_W-1:0]          cities;
    route_answer_t             pending_answers[$];
    int unsigned               errors;

    function new();
      stored = 0;
      store_overflowed = 1'b0;
      cities = CITIES_RESET;
      errors = 0;
    endfunction

    function void set_cities(logic [CFG_W-1:0] value);
      cities = value;
    endfunction

    // Each round reads the costs of the round before, so a route grows by at
    // most one edge per round.
    function logic signed [OUT_W-1:0] cheapest_route(int unsigned src, int unsigned dst,
                                                     int unsigned stops);
      int unsigned       n;
      int unsigned       r;
      int unsigned       e;
      int unsigned       c;
      int unsigned       u;
      int unsigned       v;
      longint unsigned   cand;
      logic [COST_W-1:0] cost      [DEF_MAX_CITIES];
      logic [COST_W-1:0] prev_cost [DEF_MAX_CITIES];
      bit                reached      [DEF_MAX_CITIES];
      bit                prev_reached [DEF_MAX_CITIES];
      n = (cities > DEF_MAX_CITIES) ? DEF_MAX_CITIES : cities;
      if (src >= n || dst >= n) return NO_ROUTE;
      for (c = 0; c < DEF_MAX_CITIES; c++) begin
        cost[c] = '0;
        reached[c] = 1'b0;
      end
      reached[src] = 1'b1;
      for (r = 0; r <= stops; r++) begin
        prev_cost = cost;
        prev_reached = reached;
        for (e = 0; e < stored; e++) begin
          u = edge_from[e];
          v = edge_to[e];
          if (u < n && v < n && prev_reached[u]) begin
            cand = longint'(prev_cost[u]) + longint'(edge_price[e]);
            if (cand > COST_CAP) cand = COST_CAP;
            if (!reached[v] || cand < cost[v]) begin
              cost[v] = COST_W'(cand);
              reached[v] = 1'b1;
            end
          end
        end
      end
      if (!reached[dst]) return NO_ROUTE;
      return {1'b0, cost[dst]};
    endfunction

    function void note_item(logic [ACTION_W-1:0] act, logic [CITY_PORT_W-1:0] from_c,
                            logic [CITY_PORT_W-1:0] to_c, logic [PRICE_PORT_W-1:0] pr,
                            logic [CITY_PORT_W-1:0] src, logic [CITY_PORT_W-1:0] dst,
                            logic [LIMIT_W-1:0] stops);
      route_answer_t ans;
      case (act)
        ACT_ADD: begin
          if (stored < DEF_MAX_EDGES) begin
            edge_from[stored] = from_c;
            edge_to[stored] = to_c;
            edge_price[stored] = pr;
            stored++;
          end else begin
            store_overflowed = 1'b1;
          end
        end
        ACT_CLEAR: begin
          stored = 0;
        end
        ACT_QUERY: begin
          ans.cost = cheapest_route(src, dst, stops);
          ans.dropped = store_overflowed;
          pending_answers = {pending_answers, ans};
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_answer(logic signed [OUT_W-1:0] got_cost, logic got_dropped);
      route_answer_t want;
      if (pending_answers.size() == 0) begin
        report($sformatf("answer with none pending, cost %0d", got_cost));
      end else begin
        want = pending_answers.pop_front();
        if (got_cost !== want.cost)
          report($sformatf("cheapest_cost %0d, wanted %0d", got_cost, want.cost));
        if (got_dropped !== want.dropped)
          report($sformatf("edges_dropped %b, wanted %b", got_dropped, want.dropped));
      end
    endtask
  endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for hop_limited_cheapest_path_top.
// ----------------------------------------------------------------------------
// Loads edges, clears the store and runs queries through the start/busy
// command port, and checks every answer on the done strobe against a tracker
// that keeps its own copy of the edge store and recomputes each query with
// relaxation rounds. The run covers hand-picked routes, several city counts
// written through the cfg channel (zero, one, above the maximum and the
// default), random well-formed load-and-query sequences mixed with noise,
// and a full edge store that sets the sticky overflow flag.
// ----------------------------------------------------------------------------
module tb;

  import hlcp_pkg::*;
  import route_check_pkg::*;

  // The watchdog limit leaves room for a query of 64 cities with a full store
  // and 64 rounds, and for a run in which every random item were a 64-round
  // query over the largest small store.
  localparam int unsigned CYCLE_LIMIT = 10_000_000;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [ACTION_W-1:0]      action = '0;
  logic [CITY_PORT_W-1:0]   from_city = '0;
  logic [CITY_PORT_W-1:0]   to_city = '0;
  logic [PRICE_PORT_W-1:0]  price = '0;
  logic [CITY_PORT_W-1:0]   source_city = '0;
  logic [CITY_PORT_W-1:0]   dest_city = '0;
  logic [LIMIT_W-1:0]       stop_limit = '0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     done;
  logic signed [OUT_W-1:0]  cheapest_cost;
  logic                     edges_dropped;

  cheapest_route_tracker tracker = new();

  int unsigned items_sent = 0;
  int unsigned idle_pct = 0;
  int unsigned cycles = 0;
  int unsigned city_pool[$];

  hop_limited_cheapest_path_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .from_city     (from_city),
    .to_city       (to_city),
    .price         (price),
    .source_city   (source_city),
    .dest_city     (dest_city),
    .stop_limit    (stop_limit),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .done          (done),
    .cheapest_cost (cheapest_cost),
    .edges_dropped (edges_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Outputs are sampled at the rising edge, before the block's own updates
  // for that edge land, so done and the answer are the values of the cycle
  // that the edge closes. The watchdog lives here as well.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL hop_limited_cheapest_path_top");
      $finish;
    end else if (!rst && done) begin
      tracker.check_answer(cheapest_cost, edges_dropped);
    end
  end

  // Presents one item and holds it until an edge with busy low takes it.
  // Start stays high on return so the next item can follow back to back;
  // the sender idle gap, when it happens, is inserted here.
  task automatic send_item(int unsigned act, int unsigned fc, int unsigned tc, int unsigned pr,
                           int unsigned sc, int unsigned dc, int unsigned lim);
    logic [ACTION_W-1:0]     a;
    logic [CITY_PORT_W-1:0]  f;
    logic [CITY_PORT_W-1:0]  t;
    logic [PRICE_PORT_W-1:0] p;
    logic [CITY_PORT_W-1:0]  s;
    logic [CITY_PORT_W-1:0]  d;
    logic [LIMIT_W-1:0]      k;
    a = ACTION_W'(act);
    f = CITY_PORT_W'(fc);
    t = CITY_PORT_W'(tc);
    p = PRICE_PORT_W'(pr);
    s = CITY_PORT_W'(sc);
    d = CITY_PORT_W'(dc);
    k = LIMIT_W'(lim);
    action <= a;
    from_city <= f;
    to_city <= t;
    price <= p;
    source_city <= s;
    dest_city <= d;
    stop_limit <= k;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    tracker.note_item(a, f, t, p, s, d, k);
    if (a != ACT_UNUSED) items_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Fields that the action does not use still carry random values.
  task automatic add_edge(int unsigned fc, int unsigned tc, int unsigned pr);
    send_item(ACT_ADD, fc, tc, pr, $urandom, $urandom, $urandom);
  endtask

  task automatic clear_edges();
    send_item(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic ask_route(int unsigned sc, int unsigned dc, int unsigned lim);
    send_item(ACT_QUERY, $urandom, $urandom, $urandom, sc, dc, lim);
  endtask

  // Stops sending and waits for every pending answer. Adds and clears finish
  // in the cycle that takes them, so the extra wait at the end leaves the block idle.
  task automatic wait_all_answered();
    start <= 1'b0;
    while (tracker.pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cities(int unsigned value);
    wait_all_answered();
    cfg_data <= CFG_W'(value);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_cities(CFG_W'(value));
  endtask

  // Mostly a city from the current pool so that routes actually form; now
  // and then any city at all, which may fall outside the cities in use.
  function automatic int unsigned pick_city();
    if (city_pool.size() == 0 || $urandom_range(0, 4) == 0) return $urandom_range(0, 63);
    return city_pool[$urandom_range(0, city_pool.size() - 1)];
  endfunction

  function automatic int unsigned pick_price();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 15);
    return $urandom_range(0, 65535);
  endfunction

  function automatic int unsigned pick_stops();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 7);
    return $urandom_range(0, 63);
  endfunction

  // Random traffic: mostly a clear, a handful of edges among a small pool
  // of cities and a few queries over them; the rest is raw noise, including
  // the unused action. The store is kept small so that queries stay short.
  task automatic random_traffic(int unsigned count, int unsigned pct);
    int unsigned target;
    int unsigned n;
    target = items_sent + count;
    idle_pct = pct;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 15) begin
        send_item($urandom_range(0, 3), $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
      end else begin
        n = (tracker.cities > DEF_MAX_CITIES) ? DEF_MAX_CITIES : tracker.cities;
        city_pool.delete();
        repeat ($urandom_range(2, 8))
          city_pool = {city_pool,
                       (n == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1)};
        if (tracker.stored > 40 || $urandom_range(0, 99) < 80) clear_edges();
        repeat ($urandom_range(1, 12)) add_edge(pick_city(), pick_city(), pick_price());
        repeat ($urandom_range(1, 3)) ask_route(pick_city(), pick_city(), pick_stops());
        // Now and then the sender holds off until every answer is back.
        if ($urandom_range(0, 9) == 0) wait_all_answered();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, default city count. An empty store gives 0 for equal
    // endpoints and no route otherwise.
    ask_route(5, 5, 0);
    ask_route(0, 63, 63);
    // A short cheap detour against a pricey direct edge, a chain of the
    // largest price, and a free edge back to city 0.
    add_edge(0, 1, 100);
    add_edge(1, 2, 100);
    add_edge(0, 2, 500);
    add_edge(2, 63, 16'hFFFF);
    add_edge(63, 62, 16'hFFFF);
    add_edge(62, 61, 16'hFFFF);
    add_edge(63, 0, 0);
    ask_route(0, 2, 0);
    ask_route(0, 2, 1);
    ask_route(0, 63, 1);
    ask_route(0, 61, 4);
    ask_route(63, 1, 1);
    // The unused action must leave everything as it was.
    send_item(ACT_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    ask_route(63, 61, 63);
    clear_edges();
    ask_route(0, 2, 5);
    ask_route(63, 63, 63);

    // City counts above the maximum are clamped to 64.
    write_cities(127);
    random_traffic(30, 0);

    // A partial count leaves edges and endpoints above it out of queries.
    write_cities($urandom_range(2, 63));
    random_traffic(30, 52);

    // One city: only self-loops on city 0 can take part.
    write_cities(1);
    random_traffic(12, 28);

    // No city at all: every query answers no route.
    write_cities(0);
    random_traffic(8, 52);

    write_cities(64);
    random_traffic(30, 28);

    // Fill the store past its end. The extra adds are dropped and the flag
    // stays set from then on, even across a clear.
    idle_pct = 0;
    clear_edges();
    city_pool.delete();
    repeat (8) city_pool = {city_pool, $urandom_range(0, 15)};
    repeat (DEF_MAX_EDGES + 6) add_edge(pick_city(), pick_city(), $urandom_range(0, 65535));
    repeat (3) ask_route(pick_city(), pick_city(), $urandom_range(0, 2));
    ask_route(city_pool[0], pick_city(), 63);
    clear_edges();
    ask_route(7, 7, 0);
    random_traffic(10, 28);

    wait_all_answered();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("PASS hop_limited_cheapest_path_top");
    end else begin
      $display("FAIL hop_limited_cheapest_path_top");
    end
    $finish;
  end

endmodule
